[rtl/sts_pkg.sv]
`timescale 1ns / 1ps
package sts_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 1024;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int BOUND_W     = $clog2(TABLE_DEPTH + 1);

   // field widths fixed by the interface
   localparam int CFG_W  = 11;
   localparam int SLOT_W = 10;
   localparam int WORD_W = 32;

   // operation codes
   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   typedef struct packed {
      logic                     operation;
      logic [SLOT_W-1:0]        slot_index;
      logic signed [WORD_W-1:0] data_word;
   } req_type;

   typedef struct packed {
      logic              found;
      logic [SLOT_W-1:0] found_position;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PROBE_RD,
      ST_PROBE_CMP,
      ST_RESULT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load_write;
      logic search_init;
      logic probe_read;
      logic probe_update;
      logic result_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic range_empty;
      logic hit;
   } status_type;

endpackage

[rtl/sts_ctrl.sv]
`timescale 1ns / 1ps
module sts_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_operation,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  sts_pkg::status_type  status,
   output sts_pkg::cmd_type     cmd
);

   sts_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // state and output valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sts_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         sts_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_operation == sts_pkg::OP_LOAD) begin
                  cmd.load_write = 1'b1;
               end else begin
                  cmd.search_init = 1'b1;
                  state_in        = sts_pkg::ST_PROBE_RD;
               end
            end
         end
         sts_pkg::ST_PROBE_RD: begin
            if (status.range_empty) begin
               state_in = sts_pkg::ST_RESULT;
            end else begin
               cmd.probe_read = 1'b1;
               state_in       = sts_pkg::ST_PROBE_CMP;
            end
         end
         sts_pkg::ST_PROBE_CMP: begin
            cmd.probe_update = 1'b1;
            state_in = status.hit ? sts_pkg::ST_RESULT : sts_pkg::ST_PROBE_RD;
         end
         sts_pkg::ST_RESULT: begin
            // wait for the output register to be free or draining
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.result_load = 1'b1;
               state_in        = sts_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sts_pkg::ST_IDLE;
         end
      endcase
   end

   // result beat valid holds while stalled
   always_comb begin
      if (cmd.result_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/sts_dp.sv]
`timescale 1ns / 1ps
module sts_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  sts_pkg::req_type            req_data,
   input  logic                        csr_valid,
   input  logic [sts_pkg::CFG_W-1:0]   csr_data,
   input  sts_pkg::cmd_type            cmd,
   output sts_pkg::status_type         status,
   output sts_pkg::rsp_type            rsp_data
);

   logic [sts_pkg::WORD_W-1:0]        table_mem [sts_pkg::TABLE_DEPTH];
   logic [sts_pkg::CFG_W-1:0]         entries_ff;
   logic signed [sts_pkg::WORD_W-1:0] key_ff;
   logic signed [sts_pkg::WORD_W-1:0] rdata_ff;
   logic [sts_pkg::BOUND_W-1:0]       low_ff, low_in;
   logic [sts_pkg::BOUND_W-1:0]       end_ff, end_in;
   logic [sts_pkg::ADDR_W-1:0]        mid_ff, mid_in;
   logic [sts_pkg::BOUND_W:0]         mid_sum;
   logic                              hit_ff;
   sts_pkg::rsp_type                  rsp_ff;
   logic                              slot_ok;
   logic                              probe_eq;
   logic                              probe_lt;

   // search length register
   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= '0;
      end else if (csr_valid) begin
         entries_ff <= csr_data;
      end
   end

   // table memory, one write port and one registered read port
   assign slot_ok = 32'(req_data.slot_index) < 32'(sts_pkg::TABLE_DEPTH);

   always_ff @(posedge clock) begin
      if (cmd.load_write && slot_ok) begin
         table_mem[sts_pkg::ADDR_W'(req_data.slot_index)] <= req_data.data_word;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= table_mem[mid_in];
   end

   // midpoint of the live range, end is exclusive
   assign mid_sum = {1'b0, low_ff} + {1'b0, end_ff} - 1'b1;
   assign mid_in  = sts_pkg::ADDR_W'(mid_sum[sts_pkg::BOUND_W:1]);

   // probe compare
   assign probe_eq = (rdata_ff == key_ff);
   assign probe_lt = (rdata_ff < key_ff);

   assign status.range_empty = (low_ff >= end_ff);
   assign status.hit         = probe_eq;

   // bound update
   always_comb begin
      low_in = low_ff;
      end_in = end_ff;
      if (cmd.search_init) begin
         low_in = '0;
         if (32'(entries_ff) > 32'(sts_pkg::TABLE_DEPTH)) begin
            end_in = sts_pkg::BOUND_W'(sts_pkg::TABLE_DEPTH);
         end else begin
            end_in = sts_pkg::BOUND_W'(entries_ff);
         end
      end else if (cmd.probe_update && !probe_eq) begin
         if (probe_lt) begin
            low_in = sts_pkg::BOUND_W'(mid_ff) + 1'b1;
         end else begin
            end_in = sts_pkg::BOUND_W'(mid_ff);
         end
      end
   end

   // search registers
   always_ff @(posedge clock) begin
      low_ff <= low_in;
      end_ff <= end_in;
      if (cmd.search_init) begin
         key_ff <= req_data.data_word;
         hit_ff <= 1'b0;
      end else if (cmd.probe_update && probe_eq) begin
         hit_ff <= 1'b1;
      end
      if (cmd.probe_read) begin
         mid_ff <= mid_in;
      end
   end

   // result payload register
   always_ff @(posedge clock) begin
      if (cmd.result_load) begin
         rsp_ff.found          <= hit_ff;
         rsp_ff.found_position <= hit_ff ? sts_pkg::SLOT_W'(mid_ff) : '0;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

[rtl/sorted_table_binary_search.sv]
`timescale 1ns / 1ps
// sorted table binary search
// req channel: req_valid/req_stall with req_data. a load beat (operation 0)
//   writes data_word into slot_index and gives no result; a search beat
//   (operation 1) looks for data_word in the first entries_in_use slots.
// rsp channel: rsp_valid/rsp_stall with rsp_data, one beat per search:
//   found flag and the slot of the match (zero when not found).
// csr channel: csr_valid/csr_ready with csr_data, writes entries_in_use;
//   csr_ready is always high. write it only while the block is idle.
// timing: a load keeps the block idle, so the next beat is taken right after.
//   a search repeats a probe (registered table read, then compare and
//   bound update) until a hit or until it finds the range empty when the
//   key is absent, then loads the result into the output register once
//   that register is free or draining.
//   req_stall stays high until the search result sits in the output register.
// stall: the result holds in the output register while rsp_stall is high;
//   the block takes the next beat meanwhile, and a later search waits for
//   the register to drain before it finishes.
// reset: clears the state machine, the output valid and entries_in_use;
//   table contents are undefined until loaded.
module sorted_table_binary_search (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  sts_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output sts_pkg::rsp_type          rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [sts_pkg::CFG_W-1:0] csr_data
);

   sts_pkg::cmd_type    cmd;
   sts_pkg::status_type status;

   assign csr_ready = 1'b1;

   // control
   sts_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_data.operation),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .status        (status),
      .cmd           (cmd)
   );

   // table and search datapath
   sts_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule
